FILE: hdl/dcpm_pkg.sv
// dcpm_pkg: shared types and constants for the DNA complement pattern matcher.
// Used by the interfaces, the controller, the datapath and the top level.
package dcpm_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 16;

	localparam logic [BYTE_W-1:0] CH_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_T = 8'h54;
	localparam logic [BYTE_W-1:0] CH_C = 8'h43;
	localparam logic [BYTE_W-1:0] CH_G = 8'h47;
	localparam logic [BYTE_W-1:0] CH_X = 8'h58;

	localparam logic REQ_PROBE = 1'b0;
	localparam logic REQ_TEXT  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic accept_probe;
		logic accept_text;
		logic eval;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic result;
	} dp_sts_t;

	function automatic logic [BYTE_W-1:0] complement_of(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		unique case (b)
			CH_A:    r = CH_T;
			CH_T:    r = CH_A;
			CH_C:    r = CH_G;
			CH_G:    r = CH_C;
			default: r = CH_X;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/dcpm_in_if.sv
// dcpm_in_if: request channel (probe or text byte) with valid/ready handshake.
// Depends on dcpm_pkg for field widths.
interface dcpm_in_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [dcpm_pkg::BYTE_W-1:0]     base_byte;
	logic                            is_last;

	modport source (output valid, req_type, base_byte, is_last, input ready);
	modport sink   (input valid, req_type, base_byte, is_last, output ready);
endinterface

FILE: hdl/dcpm_out_if.sv
// dcpm_out_if: result channel (match position or no-match) with valid/ready handshake.
// Depends on dcpm_pkg for field widths.
interface dcpm_out_if;
	logic                            valid;
	logic                            ready;
	logic [dcpm_pkg::POS_W-1:0]      match_position;
	logic                            match_found;
	logic                            no_match;

	modport source (output valid, match_position, match_found, no_match, input ready);
	modport sink   (input valid, match_position, match_found, no_match, output ready);
endinterface

FILE: hdl/dna_complement_pattern_match_top.sv
// dna_complement_pattern_match_top: probe complement search over a text stream.
// Probe beats shift the probe line; text beats shift the window, then the eval state
// compares all MAX_PROBE lanes in parallel and a result, if any, is registered.
// A new beat is not accepted during the controller's eval step.
// Async active-low reset clears probe length, text index, flags and search_start.
module dna_complement_pattern_match_top #(
	parameter int MAX_PROBE = 16,
	parameter int MAX_TEXT  = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dcpm_in_if.sink                     req,
	dcpm_out_if.source                  rsp,
	input  logic                        cfg_wr_en,
	input  logic [dcpm_pkg::POS_W-1:0]  cfg_wr_data
);

	dcpm_pkg::dp_cmd_t           cmd;
	dcpm_pkg::dp_sts_t           sts;
	logic                        rsp_valid;
	logic [dcpm_pkg::POS_W-1:0]  dp_pos;
	logic                        dp_found;
	logic                        dp_nomatch;

	dcpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dcpm_datapath #(
		.MAX_PROBE (MAX_PROBE),
		.MAX_TEXT  (MAX_TEXT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.base_byte      (req.base_byte),
		.is_last        (req.is_last),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.match_position (dp_pos),
		.match_found    (dp_found),
		.no_match       (dp_nomatch)
	);

	dcpm_rsp_drive u_rsp (
		.rsp_valid_i (rsp_valid),
		.pos_i       (dp_pos),
		.found_i     (dp_found),
		.nomatch_i   (dp_nomatch),
		.pos_o       (rsp.match_position),
		.found_o     (rsp.match_found),
		.nomatch_o   (rsp.no_match)
	);

	assign rsp.valid = rsp_valid;

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.match_found ^ rsp.no_match))
		else $error("result beat is neither exactly a match nor a no-match");

	a_text_evals: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept_text |=> cmd.eval)
		else $error("text beat not followed by an eval cycle");

	a_no_accept_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> !req.ready)
		else $error("request accepted during eval");

	a_nomatch_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.no_match) |-> (rsp.match_position == '0))
		else $error("no-match beat carries a nonzero position");

endmodule

FILE: hdl/dcpm_ctrl.sv
// dcpm_ctrl: handshake controller; issues accept/eval commands to the datapath
// and owns the result valid flag. Depends on dcpm_pkg.
module dcpm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_type,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dcpm_pkg::dp_cmd_t  cmd,
	input  dcpm_pkg::dp_sts_t  sts
);

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fire;

	// result register must be empty, or drained this cycle, before a new beat
	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign fire      = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.accept_probe = fire && (req_type == dcpm_pkg::REQ_PROBE);
		cmd.accept_text  = fire && (req_type == dcpm_pkg::REQ_TEXT);
		cmd.eval         = (state_q == ST_EVAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && rsp_ready) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.accept_text) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.result) begin
						out_valid_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/dcpm_datapath.sv
// dcpm_datapath: probe complement shift line, text window, index tracking,
// parallel window compare and result register. Depends on dcpm_pkg.
module dcpm_datapath #(
	parameter int MAX_PROBE = 16,
	parameter int MAX_TEXT  = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dcpm_pkg::dp_cmd_t             cmd,
	output dcpm_pkg::dp_sts_t             sts,
	input  logic [dcpm_pkg::BYTE_W-1:0]   base_byte,
	input  logic                          is_last,
	input  logic                          cfg_wr_en,
	input  logic [dcpm_pkg::POS_W-1:0]    cfg_wr_data,
	output logic [dcpm_pkg::POS_W-1:0]    match_position,
	output logic                          match_found,
	output logic                          no_match
);

	localparam int LW = $clog2(MAX_PROBE + 1);
	localparam int IW = $clog2(MAX_TEXT + 1);
	localparam int WW = ((IW > dcpm_pkg::POS_W) ? IW : dcpm_pkg::POS_W) + 1;
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PROBE);
	localparam logic [IW-1:0] IDX_MAX = IW'(MAX_TEXT);

	// probe kept as a shift line: probe_q[k] holds complement byte len-1-k,
	// which lines up lane by lane with the text window
	logic [dcpm_pkg::BYTE_W-1:0] probe_q [MAX_PROBE];
	logic [dcpm_pkg::BYTE_W-1:0] win_q   [MAX_PROBE];
	logic [LW-1:0]               plen_q;
	logic                        pdone_q;
	logic [IW-1:0]               tidx_q;
	logic                        any_q;
	logic                        ended_q;
	logic [dcpm_pkg::POS_W-1:0]  start_q;

	logic [IW-1:0]               idx_s1;
	logic                        inr_s1;
	logic                        last_s1;

	logic [dcpm_pkg::POS_W-1:0]  pos_q;
	logic                        found_q;
	logic                        nomatch_q;

	logic [LW-1:0]               plen_base;
	logic [IW-1:0]               idx_eff;
	logic [MAX_PROBE-1:0]        lane_ok;
	logic [WW-1:0]               idx_w;
	logic [WW-1:0]               len_w;
	logic [WW-1:0]               pos_w;
	logic                        reach;
	logic                        hit;
	logic                        nomatch;

	assign plen_base = pdone_q ? '0 : plen_q;
	assign idx_eff   = ended_q ? '0 : tidx_q;

	always_comb begin
		for (int k = 0; k < MAX_PROBE; k++) begin
			lane_ok[k] = (LW'(k) >= plen_q) || (win_q[k] == probe_q[k]);
		end
	end

	assign idx_w = WW'(idx_s1);
	assign len_w = WW'(plen_q);
	assign pos_w = (plen_q == '0) ? idx_w : (idx_w + WW'(1) - len_w);
	assign reach = (idx_w + WW'(1)) >= len_w;
	assign hit   = inr_s1 && ((plen_q == '0) || (reach && (&lane_ok)))
		&& (pos_w >= WW'(start_q));
	assign nomatch = !hit && last_s1 && !any_q;

	assign sts.result = hit || nomatch;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			pdone_q <= 1'b0;
			tidx_q  <= '0;
			any_q   <= 1'b0;
			ended_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
			end
			if (cmd.accept_probe) begin
				tidx_q  <= '0;
				any_q   <= 1'b0;
				ended_q <= 1'b0;
				pdone_q <= is_last;
				plen_q  <= (plen_base < LEN_MAX) ? plen_base + LW'(1) : plen_base;
			end else if (cmd.accept_text) begin
				if (ended_q) begin
					any_q <= 1'b0;
				end
				ended_q <= is_last;
				tidx_q  <= (idx_eff < IDX_MAX) ? idx_eff + IW'(1) : idx_eff;
			end else if (cmd.eval && hit) begin
				any_q <= 1'b1;
			end
		end
	end

	// payload: shift lines, evaluation stage, result register
	always_ff @(posedge clk) begin
		if (cmd.accept_probe && (plen_base < LEN_MAX)) begin
			probe_q[0] <= dcpm_pkg::complement_of(base_byte);
			for (int k = 1; k < MAX_PROBE; k++) begin
				probe_q[k] <= probe_q[k-1];
			end
		end
		if (cmd.accept_text) begin
			win_q[0] <= base_byte;
			for (int k = 1; k < MAX_PROBE; k++) begin
				win_q[k] <= win_q[k-1];
			end
			idx_s1  <= idx_eff;
			inr_s1  <= (idx_eff < IDX_MAX);
			last_s1 <= is_last;
		end
		if (cmd.eval && sts.result) begin
			pos_q     <= hit ? pos_w[dcpm_pkg::POS_W-1:0] : '0;
			found_q   <= hit;
			nomatch_q <= nomatch;
		end
	end

	assign match_position = pos_q;
	assign match_found    = found_q;
	assign no_match       = nomatch_q;

endmodule

FILE: hdl/dcpm_ctrl_tb_free.sv
// dcpm_rsp_drive: result port drive; gates the result flags with the result valid.
// Depends on dcpm_pkg.
module dcpm_rsp_drive (
	input  logic                          rsp_valid_i,
	input  logic [dcpm_pkg::POS_W-1:0]    pos_i,
	input  logic                          found_i,
	input  logic                          nomatch_i,
	output logic [dcpm_pkg::POS_W-1:0]    pos_o,
	output logic                          found_o,
	output logic                          nomatch_o
);

	// flags read as zero while no beat is offered
	assign pos_o     = pos_i;
	assign found_o   = found_i && rsp_valid_i;
	assign nomatch_o = nomatch_i && rsp_valid_i;

endmodule
